[rtl/mono_page_framebuffer_draw_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the framebuffer draw unit checker
// All properties are clocked on aclk; the plain forms drop out during reset.
// ----------------------------------------------------------------------------
`ifndef MONO_PAGE_FRAMEBUFFER_DRAW_UNIT_MACROS_SVH
`define MONO_PAGE_FRAMEBUFFER_DRAW_UNIT_MACROS_SVH

// next-cycle implication, disabled while aresetn is low
`define MPFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define MPFB_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mpfb_pkg.sv]
// ----------------------------------------------------------------------------
// mpfb_pkg
// Shared types and constants of the page framebuffer draw unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpfb_pkg;

    // widest store address (256 columns x 32 pages)
    localparam int ADDR_MAX_W = 13;
    // width used to compare byte indexes against the store size
    localparam int IDX_EXT_W  = 14;
    // y to page shift: eight rows per byte
    localparam int PAGE_SHIFT = 3;

    // s_tdata layout, lowest bit first
    localparam int S_TDATA_W  = 80;
    localparam int F_X_LSB    = 0;
    localparam int F_Y_LSB    = 8;
    localparam int F_XE_LSB   = 16;
    localparam int F_YE_LSB   = 24;
    localparam int F_COL_LSB  = 32;
    localparam int F_PAGE_LSB = 40;
    localparam int F_BITS_LSB = 45;
    localparam int F_GW_LSB   = 53;
    localparam int F_GH_LSB   = 61;
    localparam int F_RIDX_LSB = 69;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_RECT  = 2'd1,
        KIND_GLYPH = 2'd2,
        KIND_READ  = 2'd3
    } item_kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_WB,
        ST_HOLD
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_READ,
        OP_DRAW,
        OP_CLEAR
    } op_kind_t;

    // one store access, issued as a read; writes follow in the next cycle
    typedef struct packed {
        op_kind_t                kind;
        logic [ADDR_MAX_W-1:0]   addr;
        logic [7:0]              mask;
    } op_t;

    // store write port
    typedef struct packed {
        logic                    en;
        logic [ADDR_MAX_W-1:0]   addr;
        logic [7:0]              data;
    } wr_t;

    // result register control
    typedef struct packed {
        logic load_out;
        logic load_hold;
        logic from_hold;
    } ctl_t;

endpackage

`default_nettype wire

[rtl/mpfb_ram.sv]
// ----------------------------------------------------------------------------
// mpfb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpfb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/mpfb_seq.sv]
// ----------------------------------------------------------------------------
// mpfb_seq
// Item sequencer: clears the store after reset, takes items and issues one
// byte access per cycle (address plus pixel mask) into the store pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpfb_seq #(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [mpfb_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic [1:0]                         s_tuser,
    input  wire logic                               out_free,
    output mpfb_pkg::op_t                           op,
    output mpfb_pkg::ctl_t                          ctl
);

    import mpfb_pkg::*;

    localparam int PAGES    = (HEIGHT + 7) / 8;
    localparam int FB_BYTES = WIDTH * PAGES;
    localparam int ADDR_W   = $clog2(FB_BYTES);

    localparam logic [8:0]            WIDTH_V    = 9'(WIDTH);
    localparam logic [8:0]            HEIGHT_V   = 9'(HEIGHT);
    localparam logic [7:0]            X_MAX      = 8'(WIDTH - 1);
    localparam logic [7:0]            Y_MAX      = 8'(HEIGHT - 1);
    localparam logic [ADDR_W-1:0]     CLR_LAST   = ADDR_W'(FB_BYTES - 1);
    localparam logic [IDX_EXT_W-1:0]  FB_BYTES_V = IDX_EXT_W'(FB_BYTES);

    state_t state_reg, state_next;

    // input fields
    item_kind_t in_kind;
    logic [7:0] in_x, in_y, in_xe, in_ye, in_col, in_bits, in_gw, in_gh;
    logic [4:0] in_page;
    logic [9:0] in_ridx;
    logic       accept;

    assign in_kind = item_kind_t'(s_tuser);
    assign in_x    = s_tdata[F_X_LSB    +: 8];
    assign in_y    = s_tdata[F_Y_LSB    +: 8];
    assign in_xe   = s_tdata[F_XE_LSB   +: 8];
    assign in_ye   = s_tdata[F_YE_LSB   +: 8];
    assign in_col  = s_tdata[F_COL_LSB  +: 8];
    assign in_page = s_tdata[F_PAGE_LSB +: 5];
    assign in_bits = s_tdata[F_BITS_LSB +: 8];
    assign in_gw   = s_tdata[F_GW_LSB   +: 8];
    assign in_gh   = s_tdata[F_GH_LSB   +: 8];
    assign in_ridx = s_tdata[F_RIDX_LSB +: 10];
    assign accept  = s_tvalid && s_tready;

    // item registers
    item_kind_t  kind_reg;
    logic [7:0]  cur_col_reg, first_col_reg, last_col_reg;
    logic [4:0]  cur_pg_reg, last_pg_reg;
    logic        empty_reg;
    logic [7:0]  lo_row_reg, hi_row_reg, gy_reg, gbits_reg, gh_reg;
    logic [4:0]  gpage_reg;
    logic [9:0]  ridx_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // ---------------------------------------------------------------------
    // Setup of the byte walk from the incoming item
    // ---------------------------------------------------------------------
    logic [7:0] rx1, ry1, rxl, ryl, gxt, gy;
    logic       r_empty, g_empty, rd_empty;
    logic [7:0] su_first_col, su_last_col;
    logic [4:0] su_first_pg, su_last_pg;
    logic       su_empty;

    always_comb begin
        // a pixel is a one-by-one rectangle
        rx1     = (in_kind == KIND_PIXEL) ? in_x : in_xe;
        ry1     = (in_kind == KIND_PIXEL) ? in_y : in_ye;
        r_empty = (in_x > rx1) || (in_y > ry1) ||
                  ({1'b0, in_x} >= WIDTH_V) || ({1'b0, in_y} >= HEIGHT_V);
        rxl     = ({1'b0, rx1} >= WIDTH_V)  ? X_MAX : rx1;
        ryl     = ({1'b0, ry1} >= HEIGHT_V) ? Y_MAX : ry1;
        // glyph target column and first row, both wrap at 256
        gxt     = in_x + in_col;
        gy      = in_y + (8'(in_page) << PAGE_SHIFT);
        g_empty = (in_col >= in_gw) || ({1'b0, gxt} >= WIDTH_V);
        rd_empty = {4'b0, in_ridx} >= FB_BYTES_V;

        su_first_col = in_x;
        su_last_col  = rxl;
        su_first_pg  = in_y[7:PAGE_SHIFT];
        su_last_pg   = ryl[7:PAGE_SHIFT];
        su_empty     = r_empty;
        case (in_kind)
            KIND_GLYPH: begin
                su_first_col = gxt;
                su_last_col  = gxt;
                su_first_pg  = gy[7:PAGE_SHIFT];
                su_last_pg   = gy[7:PAGE_SHIFT] + 5'd1;
                su_empty     = g_empty;
            end
            KIND_READ: begin
                su_first_col = '0;
                su_last_col  = '0;
                su_first_pg  = '0;
                su_last_pg   = '0;
                su_empty     = rd_empty;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Byte access for the current walk position
    // ---------------------------------------------------------------------
    logic [7:0]           mask_r, mask_g, row, boff;
    logic [IDX_EXT_W-1:0] pg_base, byte_addr;
    logic                 walk_last, issue_last;
    op_t                  issue_op;

    always_comb begin
        row  = '0;
        boff = '0;
        for (int t = 0; t < 8; t++) begin
            row       = {cur_pg_reg, 3'(t)};
            boff      = row - gy_reg;
            mask_r[t] = ({1'b0, row} < HEIGHT_V) && (row >= lo_row_reg) &&
                        (row <= hi_row_reg);
            mask_g[t] = ({1'b0, row} < HEIGHT_V) && (boff[7:3] == 5'd0) &&
                        gbits_reg[boff[2:0]] && ({gpage_reg, boff[2:0]} < gh_reg);
        end
        pg_base   = IDX_EXT_W'(cur_pg_reg) * IDX_EXT_W'(WIDTH_V);
        byte_addr = pg_base + IDX_EXT_W'(cur_col_reg);
        walk_last = (cur_col_reg == last_col_reg) && (cur_pg_reg == last_pg_reg);

        issue_op.kind = OP_NONE;
        issue_op.addr = ADDR_MAX_W'(byte_addr);
        issue_op.mask = mask_r;
        issue_last    = walk_last || empty_reg;
        case (kind_reg)
            KIND_READ: begin
                issue_op.kind = empty_reg ? OP_NONE : OP_READ;
                issue_op.addr = ADDR_MAX_W'(ridx_reg);
                issue_last    = 1'b1;
            end
            KIND_GLYPH: begin
                issue_op.mask = mask_g;
                issue_op.kind = (!empty_reg && (mask_g != 8'd0)) ? OP_DRAW : OP_NONE;
            end
            default: begin
                issue_op.kind = (!empty_reg && (mask_r != 8'd0)) ? OP_DRAW : OP_NONE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (issue_last) begin
                    state_next = ST_WB;
                end
            end
            ST_WB, ST_HOLD: begin
                if (out_free) begin
                    state_next = s_tvalid ? ST_ISSUE : ST_IDLE;
                end else begin
                    state_next = ST_HOLD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Outputs
    // ---------------------------------------------------------------------
    always_comb begin
        s_tready = 1'b0;
        ctl      = '0;
        op.kind  = OP_NONE;
        op.addr  = '0;
        op.mask  = '0;
        case (state_reg)
            ST_CLEAR: begin
                op.kind = OP_CLEAR;
                op.addr = ADDR_MAX_W'(clr_cnt_reg);
            end
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_ISSUE: begin
                op = issue_op;
            end
            ST_WB: begin
                s_tready      = out_free;
                ctl.load_out  = out_free;
                ctl.load_hold = !out_free;
            end
            ST_HOLD: begin
                s_tready      = out_free;
                ctl.load_out  = out_free;
                ctl.from_hold = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // state and clear sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
        end
    end

    // item capture and walk advance
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg      <= in_kind;
            cur_col_reg   <= su_first_col;
            first_col_reg <= su_first_col;
            last_col_reg  <= su_last_col;
            cur_pg_reg    <= su_first_pg;
            last_pg_reg   <= su_last_pg;
            empty_reg     <= su_empty;
            lo_row_reg    <= in_y;
            hi_row_reg    <= ry1;
            gy_reg        <= gy;
            gpage_reg     <= in_page;
            gbits_reg     <= in_bits;
            gh_reg        <= in_gh;
            ridx_reg      <= in_ridx;
        end else if (state_reg == ST_ISSUE) begin
            if (cur_col_reg == last_col_reg) begin
                cur_col_reg <= first_col_reg;
                cur_pg_reg  <= cur_pg_reg + 5'd1;
            end else begin
                cur_col_reg <= cur_col_reg + 8'd1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/mpfb_rmw.sv]
// ----------------------------------------------------------------------------
// mpfb_rmw
// Modify and write-back stage: merges the pixel mask into the byte read in the
// cycle before, writes clear-pass zeros, and returns read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpfb_rmw (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire mpfb_pkg::op_t op_in,
    input  wire logic [7:0]    rd_data,
    input  wire logic          draw_color,
    output mpfb_pkg::wr_t      wr,
    output logic      [7:0]    res_data
);

    import mpfb_pkg::*;

    op_kind_t              stage_kind_reg;
    logic [ADDR_MAX_W-1:0] stage_addr_reg;
    logic [7:0]            stage_mask_reg;

    // stage register, lines up with the RAM read latency
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_kind_reg <= OP_NONE;
        end else begin
            stage_kind_reg <= op_in.kind;
        end
    end

    always_ff @(posedge aclk) begin
        stage_addr_reg <= op_in.addr;
        stage_mask_reg <= op_in.mask;
    end

    // merge and write back
    always_comb begin
        wr.en    = 1'b0;
        wr.addr  = stage_addr_reg;
        wr.data  = '0;
        res_data = '0;
        case (stage_kind_reg)
            OP_DRAW: begin
                wr.en   = 1'b1;
                wr.data = draw_color ? (rd_data | stage_mask_reg)
                                     : (rd_data & ~stage_mask_reg);
            end
            OP_CLEAR: begin
                wr.en = 1'b1;
            end
            OP_READ: begin
                res_data = rd_data;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/mono_page_framebuffer_draw_unit.sv]
// Results: every item yields one m_tvalid transfer once its store walk is done.
// Throughput: one store byte per cycle through a single read-modify-write pipe
//   while an item is walked; a new item is taken only once the walk of the last
//   one is done and the output register is free to take its result.
// Reset: the store is zeroed by a sweep over all WIDTH * ceil(HEIGHT/8) bytes
//   (1024 by default) with s_tready low; draw_color returns to 1.
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_unit
// Drawing engine over a page-organized monochrome framebuffer held in RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mono_page_framebuffer_draw_unit #(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration: draw_color
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_data,
    // items
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // x_coord, y_coord, x_end, y_end, glyph_column, glyph_page, glyph_bits,
    // glyph_width, glyph_height, read_index, one zero pad bit
    input  wire logic [mpfb_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic [1:0]                     s_tuser,
    // results
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // read_data
    output logic      [7:0]                     m_tdata
);

    import mpfb_pkg::*;

    localparam int PAGES    = (HEIGHT + 7) / 8;
    localparam int FB_BYTES = WIDTH * PAGES;
    localparam int ADDR_W   = $clog2(FB_BYTES);

    op_t        seq_op;
    ctl_t       ctl;
    wr_t        wr;
    logic [7:0] rd_data, res_data;
    logic       out_free;
    logic       draw_color_reg;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg, hold_reg;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    mpfb_seq #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .out_free (out_free),
        .op       (seq_op),
        .ctl      (ctl)
    );

    mpfb_ram #(
        .DATA_W (8),
        .DEPTH  (FB_BYTES)
    ) u_frame_store (
        .clk     (aclk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr[ADDR_W-1:0]),
        .wr_data (wr.data),
        .rd_addr (seq_op.addr[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    mpfb_rmw u_rmw (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op_in      (seq_op),
        .rd_data    (rd_data),
        .draw_color (draw_color_reg),
        .wr         (wr),
        .res_data   (res_data)
    );

    // draw color register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draw_color_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            draw_color_reg <= cfg_data;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result data, parked in the hold register while the output is busy
    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            m_tdata_reg <= ctl.from_hold ? hold_reg : res_data;
        end
        if (ctl.load_hold) begin
            hold_reg <= res_data;
        end
    end

endmodule

`default_nettype wire

[rtl/mpfb_checker.sv]
// ----------------------------------------------------------------------------
// mpfb_checker
// Port-level checks of the framebuffer draw unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mono_page_framebuffer_draw_unit_macros.svh"

module mpfb_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [1:0]                     s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [7:0]                     m_tdata
);

    import mpfb_pkg::*;

    // a stalled result holds
    `MPFB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // store clear sweep follows every reset
    `MPFB_ASSERT_NEXT_ALWAYS(a_clear_after_reset, !aresetn, !s_tready, "item taken during clear sweep")

    // one item at a time
    `MPFB_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "item taken while one is in flight")

    // a pixel item yields a zero result after its single store access once the output is free
    `MPFB_ASSERT_NEXT(a_pixel_result, (s_tvalid && s_tready && s_tuser == KIND_PIXEL) ##2 (!m_tvalid || m_tready), m_tvalid && m_tdata == 8'd0, "pixel result late or nonzero")

endmodule

bind mono_page_framebuffer_draw_unit mpfb_checker u_mpfb_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire

[test/fb_draw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fb_draw_checker
// Watches the config, item and result channels of the draw unit, keeps a
// shadow copy of the framebuffer and the draw color, predicts read_data for
// every accepted item and compares each result transfer with it in order.
// ----------------------------------------------------------------------------
module fb_draw_checker
    import mpfb_pkg::*;
#(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic                 cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [7:0]           m_tdata,
    output int                   fail_count,
    output int                   pending,
    output int                   results_seen
);

    localparam int FB_BYTES = WIDTH * ((HEIGHT + 7) / 8);

    logic [7:0] shadow_fb [FB_BYTES];
    logic       shadow_color;
    logic [7:0] read_data_q [$];
    logic [7:0] want;
    int         mism = 0;
    int         seen = 0;

    initial begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
    end

    // one pixel to the current color, clipped to the screen
    function automatic void plot(input int unsigned x, input int unsigned y);
        int unsigned addr;
        if (x >= WIDTH || y >= HEIGHT) return;
        addr = x + (y >> 3) * WIDTH;
        shadow_fb[addr][y & 7] = shadow_color;
    endfunction

    // apply one item to the shadow store; returns the read_data it yields
    function automatic logic [7:0] apply_draw_item(input logic [1:0] k,
                                                   input logic [S_TDATA_W-1:0] d);
        int unsigned x0   = d[F_X_LSB +: 8];
        int unsigned y0   = d[F_Y_LSB +: 8];
        int unsigned x1   = d[F_XE_LSB +: 8];
        int unsigned y1   = d[F_YE_LSB +: 8];
        int unsigned col  = d[F_COL_LSB +: 8];
        int unsigned page = d[F_PAGE_LSB +: 5];
        logic [7:0]  bits = d[F_BITS_LSB +: 8];
        int unsigned gw   = d[F_GW_LSB +: 8];
        int unsigned gh   = d[F_GH_LSB +: 8];
        int unsigned ridx = d[F_RIDX_LSB +: 10];
        int unsigned row;
        case (k)
            KIND_PIXEL: plot(x0, y0);
            KIND_RECT: begin
                // inclusive bounds, no wrap at 255; columns and rows past the screen are clipped
                for (int unsigned cx = x0; cx <= x1 && cx < WIDTH; cx++)
                    for (int unsigned cy = y0; cy <= y1 && cy < HEIGHT; cy++)
                        plot(cx, cy);
            end
            KIND_GLYPH: begin
                if (col < gw) begin
                    for (int b = 0; b < 8; b++) begin
                        row = page * 8 + b;
                        if (row >= gh) break;
                        // 8-bit wrap of the target before clipping
                        if (bits[b]) plot((x0 + col) & 255, (y0 + row) & 255);
                    end
                end
            end
            default: begin
                if (ridx < FB_BYTES) return shadow_fb[ridx];
            end
        endcase
        return 8'h00;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
            shadow_color = 1'b1;
            read_data_q.delete();
        end else begin
            // result side first so a same-edge item never pairs with its own result
            if (m_tvalid && m_tready) begin
                seen++;
                if (read_data_q.size() == 0) begin
                    mism++;
                    $display("%0t: read_data expected none, actual %02h", $time, m_tdata);
                end else begin
                    want = read_data_q.pop_front();
                    if (m_tdata !== want) begin
                        mism++;
                        $display("%0t: read_data expected %02h, actual %02h",
                                 $time, want, m_tdata);
                    end
                end
            end
            if (cfg_valid && cfg_ready) shadow_color = cfg_data;
            if (s_tvalid && s_tready)
                read_data_q.push_back(apply_draw_item(s_tuser, s_tdata));
        end
        fail_count   <= mism;
        pending      <= read_data_q.size();
        results_seen <= seen;
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the framebuffer draw unit with directed corner items, then with
// phases of random pixels, fills, glyph bytes and reads under both draw
// colors, with random source gaps and sink stalls; the checker compares.
// ----------------------------------------------------------------------------
module testbench;
    import mpfb_pkg::*;

    localparam int WIDTH     = 128;
    localparam int HEIGHT    = 64;
    localparam int LIMIT     = 1_000_000;
    localparam int PHASES    = 6;
    localparam int PHASE_LEN = 200;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] x0;
        logic [7:0] y0;
        logic [7:0] x1;
        logic [7:0] y1;
        logic [7:0] col;
        logic [4:0] page;
        logic [7:0] bits;
        logic [7:0] gw;
        logic [7:0] gh;
        logic [9:0] ridx;
    } draw_item_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_data  = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [1:0]           s_tuser   = 2'b00;
    logic                 m_tready  = 1'b0;
    wire                  cfg_ready;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [7:0]           m_tdata;

    int   fail_count;
    int   pending;
    int   results_seen;
    bit   src_idle     = 1'b1;
    bit   sink_idle    = 1'b1;
    int   stall_left   = 0;
    int   cycles       = 0;
    int   kind_count [4];
    int   color_writes = 0;
    logic phase_color [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    mono_page_framebuffer_draw_unit #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    fb_draw_checker #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // sink: random stall bursts while enabled
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (sink_idle && $urandom_range(0, 4) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog
    initial begin
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("** mono_page_framebuffer_draw_unit: FAILED **");
        $finish;
    end

    function automatic logic [S_TDATA_W-1:0] pack_fields(input draw_item_t it);
        logic [S_TDATA_W-1:0] d = '0;
        d[F_X_LSB +: 8]     = it.x0;
        d[F_Y_LSB +: 8]     = it.y0;
        d[F_XE_LSB +: 8]    = it.x1;
        d[F_YE_LSB +: 8]    = it.y1;
        d[F_COL_LSB +: 8]   = it.col;
        d[F_PAGE_LSB +: 5]  = it.page;
        d[F_BITS_LSB +: 8]  = it.bits;
        d[F_GW_LSB +: 8]    = it.gw;
        d[F_GH_LSB +: 8]    = it.gh;
        d[F_RIDX_LSB +: 10] = it.ridx;
        return d;
    endfunction

    function automatic draw_item_t op_item(input item_kind_t k, input int x, input int y,
                                           input int xe, input int ye);
        draw_item_t it = '0;
        it.kind = k;
        it.x0   = x;
        it.y0   = y;
        it.x1   = xe;
        it.y1   = ye;
        return it;
    endfunction

    function automatic draw_item_t glyph_item(input int x, input int y, input int col,
                                              input int page, input int bits,
                                              input int gw, input int gh);
        draw_item_t it = '0;
        it.kind = KIND_GLYPH;
        it.x0   = x;
        it.y0   = y;
        it.col  = col;
        it.page = page;
        it.bits = bits;
        it.gw   = gw;
        it.gh   = gh;
        return it;
    endfunction

    function automatic draw_item_t read_item(input int idx);
        draw_item_t it = '0;
        it.kind = KIND_READ;
        it.ridx = idx;
        return it;
    endfunction

    // random item: every field random, then shaped per kind so most items land on screen
    function automatic draw_item_t random_item();
        draw_item_t  it;
        int unsigned pick;
        int unsigned r;
        it.x0   = $urandom_range(0, 255);
        it.y0   = $urandom_range(0, 255);
        it.x1   = $urandom_range(0, 255);
        it.y1   = $urandom_range(0, 255);
        it.col  = $urandom_range(0, 255);
        it.page = $urandom_range(0, 31);
        it.bits = $urandom_range(0, 255);
        it.gw   = $urandom_range(0, 255);
        it.gh   = $urandom_range(0, 255);
        it.ridx = $urandom_range(0, 1023);
        pick    = $urandom_range(0, 99);
        if (pick < 30) begin
            it.kind = KIND_PIXEL;
            if ($urandom_range(0, 4) != 0) begin
                it.x0 = $urandom_range(0, WIDTH - 1);
                it.y0 = $urandom_range(0, HEIGHT - 1);
            end
        end else if (pick < 50) begin
            it.kind = KIND_RECT;
            r = $urandom_range(0, 19);
            if (r < 18) begin
                // small fills, a few crossing the right or bottom edge
                it.x0 = $urandom_range(0, WIDTH + 7);
                it.x1 = it.x0 + $urandom_range(0, 12);
                it.y0 = $urandom_range(0, HEIGHT + 7);
                it.y1 = it.y0 + $urandom_range(0, 12);
            end else if (r == 18) begin
                it.x0 = $urandom_range(0, 255);
                it.x1 = $urandom_range(it.x0, 255);
                it.y0 = $urandom_range(0, 255);
                it.y1 = $urandom_range(it.y0, 255);
            end
        end else if (pick < 80) begin
            it.kind = KIND_GLYPH;
            if ($urandom_range(0, 9) != 0) begin
                it.gw   = $urandom_range(1, 16);
                it.col  = $urandom_range(0, it.gw - 1);
                it.gh   = $urandom_range(1, 32);
                it.page = $urandom_range(0, (it.gh - 1) / 8);
            end
            if ($urandom_range(0, 3) != 0) begin
                it.x0 = $urandom_range(0, WIDTH - 1);
                it.y0 = $urandom_range(0, HEIGHT - 1);
            end
        end else begin
            it.kind = KIND_READ;
        end
        return it;
    endfunction

    // valid stays high between back-to-back items; gaps drop it first
    task automatic send_item(input draw_item_t it);
        if (src_idle && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= pack_fields(it);
        do @(posedge aclk); while (!s_tready);
        kind_count[it.kind]++;
    endtask

    // drain every outstanding result, then write draw_color
    task automatic write_color(input logic c);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        color_writes++;
    endtask

    initial begin
        foreach (kind_count[i]) kind_count[i] = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: corners, clipping, empty and edge fills, glyph limits and wrap
        write_color(1'b1);
        send_item(op_item(KIND_PIXEL, 0, 0, 0, 0));
        send_item(op_item(KIND_PIXEL, WIDTH - 1, HEIGHT - 1, 0, 0));
        send_item(op_item(KIND_PIXEL, WIDTH, 5, 0, 0));
        send_item(op_item(KIND_PIXEL, 3, HEIGHT, 0, 0));
        send_item(op_item(KIND_PIXEL, 255, 255, 255, 255));
        send_item(read_item(0));
        send_item(read_item(1023));
        send_item(op_item(KIND_RECT, 10, 0, 5, 7));
        send_item(op_item(KIND_RECT, 0, 10, 7, 5));
        send_item(op_item(KIND_RECT, 120, 56, 255, 255));
        send_item(read_item(1023 - 4));
        send_item(glyph_item(30, 8, 5, 0, 8'hFF, 5, 8));
        send_item(glyph_item(20, 8, 0, 0, 8'hFF, 8, 5));
        send_item(read_item(20 + WIDTH));
        send_item(glyph_item(250, 250, 10, 0, 8'hA5, 255, 255));
        send_item(glyph_item(40, 16, 1, 31, 8'h5A, 255, 255));
        send_item(read_item(4));
        send_item(read_item(41 + WIDTH));
        write_color(1'b0);
        send_item(op_item(KIND_PIXEL, 0, 0, 0, 0));
        send_item(glyph_item(20, 8, 0, 0, 8'h0F, 8, 255));
        send_item(read_item(20 + WIDTH));
        send_item(op_item(KIND_RECT, 0, 0, 255, 255));
        send_item(read_item(4));
        write_color(1'b1);
        send_item(op_item(KIND_RECT, 0, 0, 255, 255));
        send_item(read_item(555));

        // random phases; the third runs without idling, the last as well
        for (int p = 0; p < PHASES; p++) begin
            write_color(phase_color[p]);
            src_idle  <= (p != 2 && p != PHASES - 1);
            sink_idle <= (p != 2 && p != PHASES - 1);
            for (int n = 0; n < PHASE_LEN; n++) send_item(random_item());
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Covered %0d pixels, %0d fills, %0d glyph bytes and %0d reads; %0d results checked.",
                 kind_count[KIND_PIXEL], kind_count[KIND_RECT], kind_count[KIND_GLYPH],
                 kind_count[KIND_READ], results_seen);
        $display("draw_color written %0d times, set and clear phases, with and without stalls.",
                 color_writes);
        if (fail_count == 0) begin
            $display("** mono_page_framebuffer_draw_unit: PASSED **");
        end else begin
            $display("** mono_page_framebuffer_draw_unit: FAILED **");
        end
        $finish;
    end

endmodule
